@@ rtl/core/gof3_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gof3_pkg: shared types and constants
// Operand width, stream packing widths and the control and status bundles
// passed between the sequencer and the gcd unit.
// ----------------------------------------------------------------------------
package gof3_pkg;

    localparam int VALUE_BITS = 31;
    localparam int SHIFT_BITS = $clog2(VALUE_BITS);
    localparam int IN_BITS    = ((3 * VALUE_BITS + 7) / 8) * 8;
    localparam int OUT_BITS   = ((VALUE_BITS + 7) / 8) * 8;

    typedef logic [VALUE_BITS-1:0] t_value;

    typedef struct packed {
        logic   start;
        t_value op_a;
        t_value op_b;
    } t_gcd_ctrl;

    typedef struct packed {
        logic   done;
        t_value result;
    } t_gcd_stat;

endpackage

@@ rtl/core/gof3_gcd_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gof3_gcd_unit: iterative binary gcd of two nonzero operands
// One compare and subtract with a one-bit shift per cycle; common factors of
// two are stripped first and restored by a final shift.
// ----------------------------------------------------------------------------
module gof3_gcd_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  gof3_pkg::t_gcd_ctrl   i_ctrl,
    output gof3_pkg::t_gcd_stat   o_stat
);
    import gof3_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ALIGN,
        S_REDUCE
    } t_state;

    t_state               r_state, n_state;
    t_value               r_a, n_a;
    t_value               r_b, n_b;
    logic [SHIFT_BITS-1:0] r_k, n_k;
    logic                 r_done, n_done;
    t_value               r_result, n_result;

    t_value               w_big;
    t_value               w_little;
    t_value               w_diff;
    logic                 w_a_less;

    assign w_a_less = (r_a < r_b);
    assign w_big    = w_a_less ? r_b : r_a;
    assign w_little = w_a_less ? r_a : r_b;
    assign w_diff   = w_big - w_little;

    always_comb begin
        n_state  = r_state;
        n_a      = r_a;
        n_b      = r_b;
        n_k      = r_k;
        n_done   = 1'b0;
        n_result = r_result;
        unique case (r_state)
            S_IDLE: begin
                if (i_ctrl.start) begin
                    n_a     = i_ctrl.op_a;
                    n_b     = i_ctrl.op_b;
                    n_k     = '0;
                    n_state = S_ALIGN;
                end
            end
            S_ALIGN: begin
                // strip common factors of two
                if (!r_a[0] && !r_b[0]) begin
                    n_a = r_a >> 1;
                    n_b = r_b >> 1;
                    n_k = r_k + 1'b1;
                end else begin
                    n_state = S_REDUCE;
                end
            end
            S_REDUCE: begin
                if (r_a == r_b) begin
                    n_result = r_a << r_k;
                    n_done   = 1'b1;
                    n_state  = S_IDLE;
                end else if (!r_a[0]) begin
                    n_a = r_a >> 1;
                end else if (!r_b[0]) begin
                    n_b = r_b >> 1;
                end else if (w_a_less) begin
                    n_b = w_diff >> 1;
                end else begin
                    n_a = w_diff >> 1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_a      <= n_a;
        r_b      <= n_b;
        r_k      <= n_k;
        r_result <= n_result;
    end

    assign o_stat.done   = r_done;
    assign o_stat.result = r_result;

endmodule

@@ rtl/core/gcd_of_three.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcd_of_three: greatest common divisor of three operands
// Sequencer running the shared binary gcd unit twice: first on the first two
// operands, then on that result and the third operand.
// ----------------------------------------------------------------------------
// Usage:
//   input stream : one transaction carries the three operands in i_s_tdata.
//   output stream: one transaction per input carries the divisor in o_m_tdata.
//   if any operand is 0 or 1 the divisor is 1; it is set in r_res and then
//   loaded into the output register once that register is free.
//   otherwise each pair pass runs on the gcd unit, which first strips the
//   common factors of two and then runs shift/subtract steps until both
//   operands match; the second pass starts when the first is done, and its
//   result goes through r_res into the output register.
//   o_s_tready is high only while no item is in work, so one item at a time.
//   the result sits in an output register; the next input is taken while it
//   waits, and a finished result waits in the sequencer until the receiver
//   takes the previous one.
//   reset (synchronous, active low) drops any item in work and empties the
//   output register.
// ----------------------------------------------------------------------------
module gcd_of_three (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // first_value, second_value, third_value, zero padding
    input  logic [gof3_pkg::IN_BITS-1:0]  i_s_tdata,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // divisor, zero padding
    output logic [gof3_pkg::OUT_BITS-1:0] o_m_tdata
);
    import gof3_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PAIR1,
        S_PAIR2,
        S_DELIVER
    } t_state;

    t_state    r_state;
    t_value    r_third;
    t_value    r_res;
    t_value    r_out;
    logic      r_out_valid;

    t_value    w_first;
    t_value    w_second;
    t_value    w_third;
    logic      w_accept;
    logic      w_trivial;
    logic      w_load_out;
    t_gcd_ctrl w_ctrl;
    t_gcd_stat w_stat;

    assign w_first   = i_s_tdata[VALUE_BITS-1:0];
    assign w_second  = i_s_tdata[2*VALUE_BITS-1:VALUE_BITS];
    assign w_third   = i_s_tdata[3*VALUE_BITS-1:2*VALUE_BITS];
    assign w_accept  = i_s_tvalid && o_s_tready;
    assign w_trivial = (w_first <= t_value'(1)) || (w_second <= t_value'(1))
                    || (w_third <= t_value'(1));
    assign w_load_out = (r_state == S_DELIVER) && (!r_out_valid || i_m_tready);

    always_comb begin
        w_ctrl.start = 1'b0;
        w_ctrl.op_a  = w_first;
        w_ctrl.op_b  = w_second;
        if (r_state == S_IDLE) begin
            w_ctrl.start = w_accept && !w_trivial;
        end else if (r_state == S_PAIR1) begin
            w_ctrl.start = w_stat.done;
            w_ctrl.op_a  = w_stat.result;
            w_ctrl.op_b  = r_third;
        end
    end

    gof3_gcd_unit u_gcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_ctrl),
        .o_stat  (w_stat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_third <= w_third;
                        if (w_trivial) begin
                            r_res   <= t_value'(1);
                            r_state <= S_DELIVER;
                        end else begin
                            r_state <= S_PAIR1;
                        end
                    end
                end
                S_PAIR1: begin
                    if (w_stat.done) begin
                        r_state <= S_PAIR2;
                    end
                end
                S_PAIR2: begin
                    if (w_stat.done) begin
                        r_res   <= w_stat.result;
                        r_state <= S_DELIVER;
                    end
                end
                S_DELIVER: begin
                    if (w_load_out) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
        if (w_load_out) begin
            r_out <= r_res;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_BITS'(r_out);

endmodule
